/* src/seven_segment_weighted_scan_top_defines.svh */
// ---------------------------------------------------------------------------
// Seven-segment scan assertion macros
// Concurrent check helpers clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_WEIGHTED_SCAN_TOP_DEFINES_SVH
`define SEVEN_SEGMENT_WEIGHTED_SCAN_TOP_DEFINES_SVH

// Same-cycle implication
`define SSWS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssws: same-cycle check failed");

// Next-cycle implication
`define SSWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssws: next-cycle check failed");

`endif

/* src/ssws_pkg.sv */
// ---------------------------------------------------------------------------
// Seven-segment weighted scan package
// Beat types, character codes and segment tables.
// ---------------------------------------------------------------------------
package ssws_pkg;

  localparam int unsigned NUM_DIGITS = 3;

  localparam logic [7:0] CHAR_NUM_MAX = 8'd9;
  localparam logic [7:0] CHAR_AT      = 8'd64;
  localparam logic [7:0] CHAR_A       = 8'd97;
  localparam logic [7:0] CHAR_Z       = 8'd122;

  localparam logic [7:0] NUM_SEG [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h73
  };

  localparam logic [7:0] LET_SEG [26] = '{
    8'h7D, 8'h1F, 8'h0D, 8'h3D, 8'h6F, 8'h47, 8'h7B, 8'h17, 8'h30, 8'h3C,
    8'h57, 8'h0E, 8'h55, 8'h15, 8'h1D, 8'h67, 8'hF3, 8'h05, 8'h5B, 8'h0F,
    8'h1C, 8'h1C, 8'h5C, 8'h37, 8'h3B, 8'h6D
  };

  typedef struct packed {
    logic [7:0] char_left;
    logic [7:0] char_middle;
    logic [7:0] char_right;
    logic [7:0] custom_pattern;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] segment_pattern;
    logic [2:0] digit_enable;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] pattern;
    logic [3:0] count;
  } seg_dec_t;

endpackage

/* src/seven_segment_weighted_scan_top.sv */
// ---------------------------------------------------------------------------
// Seven-segment weighted scan
// Three-digit scanner: one beat per tick unless stalled, dwell set by lit-segment count.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_stall | in_data : chars left/middle/right, custom
//  out     | out_valid/out_stall | out_data: segment_pattern, digit_enable
//
//  One beat per cycle unless stalled; an accepted beat waits in the input
//  register until the result register is free, then its result is registered.
//  The input register feeds decode and scan update into the result register.
//  Synchronous active-low reset clears scan index, dwell, latch and enables.
//  A stalled result holds; the input stalls only while its register is full
//  and the result register is held by a stall.
// ---------------------------------------------------------------------------
`include "seven_segment_weighted_scan_top_defines.svh"

module seven_segment_weighted_scan_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssws_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ssws_pkg::out_beat_t out_data
);
  import ssws_pkg::*;

  in_beat_t   in_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  logic [1:0] scan_r, scan_nxt;
  logic [7:0] dwell_r, dwell_nxt;
  logic [7:0] anode_r, anode_nxt;
  logic [2:0] cathode_r, cathode_nxt;

  logic       out_free;
  logic       advance;
  logic       load;
  logic [7:0] dwell_dec;
  seg_dec_t   dec [NUM_DIGITS];

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign load     = in_valid && !in_stall;

  ssws_decode u_dec_left (
    .code(in_r.char_left), .custom_pattern(in_r.custom_pattern), .dec(dec[0])
  );
  ssws_decode u_dec_middle (
    .code(in_r.char_middle), .custom_pattern(in_r.custom_pattern), .dec(dec[1])
  );
  ssws_decode u_dec_right (
    .code(in_r.char_right), .custom_pattern(in_r.custom_pattern), .dec(dec[2])
  );

  assign dwell_dec = dwell_r - 8'd1;

  always_comb begin
    logic [1:0] idx;
    scan_nxt    = scan_r;
    dwell_nxt   = dwell_dec;
    anode_nxt   = anode_r;
    cathode_nxt = cathode_r;
    idx         = (scan_r == 2'd2) ? 2'd0 : scan_r + 2'd1;
    if (dwell_dec == 8'd0) begin
      // fall through blank digits towards the right
      for (int k = 0; k < NUM_DIGITS; k++) begin
        if (idx == 2'(k)) begin
          if (dec[k].count == 4'd0) begin
            cathode_nxt[k] = 1'b0;
            if (k < NUM_DIGITS - 1) begin
              idx = 2'(k + 1);
            end else begin
              dwell_nxt = 8'd1;
            end
          end else begin
            anode_nxt      = dec[k].pattern;
            cathode_nxt    = 3'b000;
            cathode_nxt[k] = 1'b1;
            dwell_nxt      = {4'd0, dec[k].count};
          end
        end
      end
      scan_nxt = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_r <= in_data;
    end
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      scan_r      <= 2'd0;
      dwell_r     <= 8'd0;
      anode_r     <= 8'h00;
      cathode_r   <= 3'b000;
    end else begin
      s1_valid_r <= load || (s1_valid_r && !advance);
      if (advance) begin
        out_valid_r <= 1'b1;
        scan_r      <= scan_nxt;
        dwell_r     <= dwell_nxt;
        anode_r     <= anode_nxt;
        cathode_r   <= cathode_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid                = out_valid_r;
  assign out_data.segment_pattern = anode_r;
  assign out_data.digit_enable    = cathode_r;

  `SSWS_ASSERT_IMPL(a_enable_onehot0, 1'b1, $onehot0(cathode_r))
  `SSWS_ASSERT_IMPL(a_scan_in_range, 1'b1, scan_r != 2'd3)
  `SSWS_ASSERT_IMPL(a_lit_has_pattern, cathode_r != 3'b000, anode_r != 8'h00)
  `SSWS_ASSERT_NEXT(a_dwell_reloaded, advance, dwell_r != 8'd0)

endmodule

/* src/ssws_decode.sv */
// ---------------------------------------------------------------------------
// Seven-segment character decoder
// Maps a character code to its segment pattern and lit-segment count.
// ---------------------------------------------------------------------------
module ssws_decode (
  input  logic [7:0]        code,
  input  logic [7:0]        custom_pattern,
  output ssws_pkg::seg_dec_t dec
);
  import ssws_pkg::*;

  logic [7:0] let_off;
  logic [7:0] pattern;

  assign let_off = code - CHAR_A;

  always_comb begin
    if (code <= CHAR_NUM_MAX) begin
      pattern = NUM_SEG[code[3:0]];
    end else if (code >= CHAR_A && code <= CHAR_Z) begin
      pattern = LET_SEG[let_off[4:0]];
    end else if (code == CHAR_AT) begin
      pattern = custom_pattern;
    end else begin
      pattern = 8'h00;
    end
  end

  assign dec.pattern = pattern;
  assign dec.count   = 4'($countones(pattern));

endmodule
